// ===== rtl/pfs_pkg.sv =====
// Shared types, codes and constants of the particle field step unit.
// Depends on nothing; every other file but pfs_ram refers to it by scoped names.
package pfs_pkg;

    localparam int MAX_PARTICLES_DEF = 2048;
    localparam int QUEUE_DEPTH       = 2;
    localparam int LIMIT_W           = 17;

    localparam logic [1:0] FUNC_SEED = 2'd0;
    localparam logic [1:0] FUNC_LAY  = 2'd1;
    localparam logic [1:0] FUNC_STEP = 2'd2;

    localparam logic [1:0] CFG_PARTICLE_COUNT = 2'd0;
    localparam logic [1:0] CFG_SEED           = 2'd1;

    localparam logic [31:0] DEFAULT_SEED = 32'h9E3779B9;
    localparam logic [12:0] DT_MAX       = 13'd6554;

    // A queued command, already classified by the front end.
    typedef struct packed {
        logic [1:0]  func;
        logic [10:0] index;
        logic        status;
        logic [12:0] dt;
        logic [31:0] clock_req;
        logic [15:0] pointer_x;
        logic [15:0] pointer_y;
    } t_cmd;

    // One particle table entry, 104 bits.
    typedef struct packed {
        logic [15:0]        x;
        logic [15:0]        y;
        logic [15:0]        depth;
        logic [15:0]        phase;
        logic signed [19:0] dx;
        logic signed [19:0] dy;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== rtl/pfs_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module pfs_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pfs_front.sv =====
// Front end: configuration registers, index check and dt clamp of each beat.
// Depends on pfs_pkg.
module pfs_front #(
    parameter int MAX_PARTICLES = pfs_pkg::MAX_PARTICLES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_func,
    input  logic [10:0]        i_index,
    input  logic signed [23:0] i_step_seconds,
    input  logic [31:0]        i_clock_req,
    input  logic [15:0]        i_pointer_x,
    input  logic [15:0]        i_pointer_y,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_q_ready,
    output logic               o_push,
    output pfs_pkg::t_cmd      o_cmd,
    output logic [31:0]        o_seed
);

    localparam logic [pfs_pkg::LIMIT_W-1:0] MaxLim = pfs_pkg::LIMIT_W'(MAX_PARTICLES);

    logic [11:0] r_count;
    logic [31:0] r_seed;
    logic [pfs_pkg::LIMIT_W-1:0] count_eff;
    logic [pfs_pkg::LIMIT_W-1:0] idx_ext;
    logic        checked;
    logic        reject;
    logic [12:0] dt_clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_seed  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pfs_pkg::CFG_PARTICLE_COUNT: r_count <= i_cfg_data[11:0];
                pfs_pkg::CFG_SEED:           r_seed  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        count_eff = (pfs_pkg::LIMIT_W'(r_count) > MaxLim) ? MaxLim
                                                          : pfs_pkg::LIMIT_W'(r_count);
        idx_ext   = pfs_pkg::LIMIT_W'(i_index);
        checked   = (i_func == pfs_pkg::FUNC_LAY) || (i_func == pfs_pkg::FUNC_STEP);
        reject    = checked && ((idx_ext >= count_eff) || (idx_ext >= MaxLim));
        if (i_step_seconds < 0) begin
            dt_clamped = '0;
        end else if (i_step_seconds > 24'sd6554) begin
            dt_clamped = pfs_pkg::DT_MAX;
        end else begin
            dt_clamped = i_step_seconds[12:0];
        end
    end

    assign o_cfg_ready      = 1'b1;
    assign o_in_ready       = i_q_ready;
    assign o_push           = i_in_valid && i_q_ready;
    assign o_seed           = r_seed;
    assign o_cmd.func       = i_func;
    assign o_cmd.index      = i_index;
    assign o_cmd.status     = reject;
    assign o_cmd.dt         = dt_clamped;
    assign o_cmd.clock_req  = i_clock_req;
    assign o_cmd.pointer_x  = i_pointer_x;
    assign o_cmd.pointer_y  = i_pointer_y;

endmodule

// ===== rtl/pfs_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on pfs_pkg.
module pfs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pfs_pkg::t_cmd i_data,
    output logic          o_ready,
    output logic          o_valid,
    output pfs_pkg::t_cmd o_data,
    input  logic          i_pop
);

    localparam int PW = (pfs_pkg::QUEUE_DEPTH > 1) ? $clog2(pfs_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(pfs_pkg::QUEUE_DEPTH + 1);

    pfs_pkg::t_cmd r_mem [pfs_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_fill;

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        f_inc = (p == PW'(pfs_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= f_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= f_inc(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + CW'(1);
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - CW'(1);
            end
        end
    end

    assign o_ready = (r_fill != CW'(pfs_pkg::QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_data  = r_mem[r_rptr];

endmodule

// ===== rtl/pfs_back.sv =====
// Back end: sequencer with one shared multiplier, the particle table, the
// generator and the output register. Depends on pfs_pkg and pfs_ram.
module pfs_back #(
    parameter int MAX_PARTICLES = pfs_pkg::MAX_PARTICLES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  pfs_pkg::t_cmd i_cmd,
    output logic          o_pop,
    input  logic [31:0]   i_seed,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [10:0]   o_particle_index,
    output logic [15:0]   o_pos_x,
    output logic [15:0]   o_pos_y,
    output logic [14:0]   o_size,
    output logic [16:0]   o_brightness,
    output logic          o_status
);

    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

    // Reciprocals for the exact constant divisions of the sine series.
    localparam logic [31:0] M3 = 32'd178956970;  // floor(2^30 / 6)
    localparam logic [31:0] M5 = 32'd143165576;  // floor(2^34 / 120)
    localparam logic [31:0] M7 = 32'd27269633;   // floor(2^37 / 5040)

    typedef enum logic [5:0] {
        ST_IDLE, ST_DRAW, ST_DEP, ST_SPD,
        ST_SIN0, ST_SIN1, ST_SIN2, ST_SIN3, ST_SIN4,
        ST_SIN5, ST_SIN6, ST_SIN7, ST_SIN8, ST_SIN9,
        ST_COS_DONE, ST_DX, ST_DY1, ST_DY2, ST_WR,
        ST_RD, ST_LD, ST_MX, ST_MY, ST_PAR, ST_PX, ST_PY,
        ST_TRN, ST_TWK, ST_BR, ST_SZ, ST_OUT
    } t_state;

    t_state             r_state;
    t_state             r_ret;
    pfs_pkg::t_cmd      r_cmd;
    logic [31:0]        r_gen;
    logic [2:0]         r_cnt;
    logic [15:0]        r_x, r_y, r_dep, r_ph, r_d, r_ang, r_turn;
    logic [18:0]        r_spd;
    logic signed [19:0] r_dx, r_dy, r_t, r_c, r_sin;
    logic [10:0]        r_par;
    logic [15:0]        r_px, r_py;
    logic [16:0]        r_twk, r_br;
    logic [14:0]        r_sz;
    logic               r_sneg;
    logic [25:0]        r_sa;
    logic [27:0]        r_sa2;
    logic [29:0]        r_sa3;
    logic [33:0]        r_sa5;
    logic [36:0]        r_sa7;
    logic [27:0]        r_q3;
    logic [26:0]        r_q5;
    logic [24:0]        r_q7;
    logic               r_ovalid;
    logic [10:0]        r_o_index;
    logic [15:0]        r_o_px, r_o_py;
    logic [14:0]        r_o_sz;
    logic [16:0]        r_o_br;
    logic               r_o_status;

    logic [37:0]        mul_a;
    logic [31:0]        mul_b;
    logic [69:0]        mul_p;
    logic [31:0]        gen_next;
    logic [16:0]        sin_mag;
    logic signed [16:0] off_x, off_y;
    logic [16:0]        base;
    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    pfs_pkg::t_entry    wr_entry;
    logic [pfs_pkg::ENTRY_W-1:0] rd_data;
    pfs_pkg::t_entry    rd_entry;
    logic [28:0]        s_pos, s_neg;
    logic [19:0]        s_mag;
    logic               s_sign;
    logic               pop;
    logic               out_load;

    function automatic logic [19:0] f_abs(input logic signed [19:0] v);
        f_abs = v[19] ? 20'(-v) : 20'(v);
    endfunction

    function automatic logic [16:0] f_abs17(input logic signed [16:0] v);
        f_abs17 = v[16] ? 17'(-v) : 17'(v);
    endfunction

    always_comb begin
        gen_next = r_gen ^ (r_gen << 13);
        gen_next = gen_next ^ (gen_next >> 17);
        gen_next = gen_next ^ (gen_next << 5);
    end

    assign sin_mag  = r_turn[15] ? (17'h10000 - 17'(r_turn)) : 17'(r_turn);
    assign off_x    = $signed({1'b0, r_cmd.pointer_x}) - 17'sd32768;
    assign off_y    = $signed({1'b0, r_cmd.pointer_y}) - 17'sd32768;
    assign base     = 17'd16384 + 17'((18'(r_dep) * 18'd3) >> 2);
    assign pop      = (r_state == ST_IDLE) && i_q_valid;
    assign out_load = (r_state == ST_OUT) && (!r_ovalid || i_out_ready);
    assign o_pop    = pop;

    // Final combination of the series terms.
    always_comb begin
        s_pos  = 29'(r_sa) + 29'(r_q5);
        s_neg  = 29'(r_q3) + 29'(r_q7);
        s_mag  = (s_pos >= s_neg) ? 20'((s_pos - s_neg) >> 8) : 20'((s_neg - s_pos) >> 8);
        s_sign = (s_pos < s_neg) ^ r_sneg;
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_DEP:  begin mul_a = 38'(r_d);               mul_b = 32'(r_d);        end
            ST_SPD:  begin mul_a = 38'(r_dep);             mul_b = 32'd335544;      end
            ST_SIN0: begin mul_a = 38'(sin_mag);           mul_b = 32'd105414357;   end
            ST_SIN1: begin mul_a = 38'(r_sa);              mul_b = 32'(r_sa);       end
            ST_SIN2: begin mul_a = 38'(r_sa2);             mul_b = 32'(r_sa);       end
            ST_SIN3: begin mul_a = 38'(r_sa3);             mul_b = 32'(r_sa2);      end
            ST_SIN4: begin mul_a = 38'(r_sa5);             mul_b = 32'(r_sa2);      end
            ST_SIN5: begin mul_a = 38'(r_sa3);             mul_b = M3;              end
            ST_SIN6: begin mul_a = 38'(r_sa5);             mul_b = M5;              end
            ST_SIN7: begin mul_a = 38'(r_sa7);             mul_b = M7;              end
            ST_DX:   begin mul_a = 38'(f_abs(r_c));        mul_b = 32'(r_spd);      end
            ST_DY1:  begin mul_a = 38'(f_abs(r_sin));      mul_b = 32'(r_spd);      end
            ST_DY2:  begin mul_a = 38'(f_abs(r_t));        mul_b = 32'd26214;       end
            ST_MX:   begin mul_a = 38'(f_abs(r_dx));       mul_b = 32'(r_cmd.dt);   end
            ST_MY:   begin mul_a = 38'(f_abs(r_dy));       mul_b = 32'(r_cmd.dt);   end
            ST_PAR:  begin mul_a = 38'(r_dep);             mul_b = 32'd1966;        end
            ST_PX:   begin mul_a = 38'(f_abs17(off_x));    mul_b = 32'(r_par);      end
            ST_PY:   begin mul_a = 38'(f_abs17(off_y));    mul_b = 32'(r_par);      end
            ST_TRN:  begin mul_a = 38'(r_cmd.clock_req);   mul_b = 32'd1162060974;  end
            ST_TWK:  begin mul_a = 38'(f_abs(r_sin));      mul_b = 32'd21299;       end
            ST_BR:   begin mul_a = 38'(base);              mul_b = 32'(r_twk);      end
            ST_SZ:   begin mul_a = 38'(r_dep);             mul_b = 32'd18022;       end
            default: ;
        endcase
    end

    assign mul_p = 70'(mul_a) * 70'(mul_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ret    <= ST_IDLE;
            r_gen    <= pfs_pkg::DEFAULT_SEED;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // A result taken by the receiver frees the register unless a new one loads.
            if (r_ovalid && i_out_ready && !out_load) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd <= i_cmd;
                        r_px  <= '0;
                        r_py  <= '0;
                        r_sz  <= '0;
                        r_br  <= '0;
                        r_cnt <= '0;
                        if (i_cmd.status) begin
                            r_state <= ST_OUT;
                        end else begin
                            case (i_cmd.func)
                                pfs_pkg::FUNC_SEED: begin
                                    r_gen   <= (i_seed != '0) ? i_seed : pfs_pkg::DEFAULT_SEED;
                                    r_state <= ST_OUT;
                                end
                                pfs_pkg::FUNC_LAY:  r_state <= ST_DRAW;
                                pfs_pkg::FUNC_STEP: r_state <= ST_RD;
                                default:            r_state <= ST_OUT;
                            endcase
                        end
                    end
                end
                ST_DRAW: begin
                    r_gen <= gen_next;
                    r_cnt <= r_cnt + 3'd1;
                    case (r_cnt)
                        3'd0:    r_x   <= gen_next[23:8];
                        3'd1:    r_y   <= gen_next[23:8];
                        3'd2:    r_d   <= gen_next[23:8];
                        3'd3:    r_ph  <= gen_next[23:8];
                        default: begin
                            r_ang   <= gen_next[23:8];
                            r_state <= ST_DEP;
                        end
                    endcase
                end
                ST_DEP: begin
                    r_dep   <= mul_p[31:16];
                    r_state <= ST_SPD;
                end
                ST_SPD: begin
                    r_spd   <= 19'(20'd67109 + 20'((36'(mul_p[35:0]) + 36'd32768) >> 16));
                    r_turn  <= r_ang + 16'h4000;
                    r_ret   <= ST_COS_DONE;
                    r_state <= ST_SIN0;
                end
                ST_SIN0: begin
                    r_sneg  <= r_turn[15];
                    r_sa    <= mul_p[41:16];
                    r_state <= ST_SIN1;
                end
                ST_SIN1: begin r_sa2 <= mul_p[51:24]; r_state <= ST_SIN2; end
                ST_SIN2: begin r_sa3 <= mul_p[53:24]; r_state <= ST_SIN3; end
                ST_SIN3: begin r_sa5 <= mul_p[57:24]; r_state <= ST_SIN4; end
                ST_SIN4: begin r_sa7 <= mul_p[60:24]; r_state <= ST_SIN5; end
                ST_SIN5: begin r_q3  <= mul_p[57:30]; r_state <= ST_SIN6; end
                ST_SIN6: begin
                    // The reciprocal estimate is at most one low: fix with the remainder.
                    if ((40'(r_sa3) - 40'(r_q3) * 40'd6) >= 40'd6) begin
                        r_q3 <= r_q3 + 28'd1;
                    end
                    r_q5    <= mul_p[60:34];
                    r_state <= ST_SIN7;
                end
                ST_SIN7: begin
                    if ((40'(r_sa5) - 40'(r_q5) * 40'd120) >= 40'd120) begin
                        r_q5 <= r_q5 + 27'd1;
                    end
                    r_q7    <= mul_p[61:37];
                    r_state <= ST_SIN8;
                end
                ST_SIN8: begin
                    if ((40'(r_sa7) - 40'(r_q7) * 40'd5040) >= 40'd5040) begin
                        r_q7 <= r_q7 + 25'd1;
                    end
                    r_state <= ST_SIN9;
                end
                ST_SIN9: begin
                    r_sin   <= s_sign ? -$signed(s_mag) : $signed(s_mag);
                    r_state <= r_ret;
                end
                ST_COS_DONE: begin
                    r_c     <= r_sin;
                    r_turn  <= r_ang;
                    r_ret   <= ST_DX;
                    r_state <= ST_SIN0;
                end
                ST_DX: begin
                    r_dx    <= r_c[19] ? -$signed(mul_p[35:16]) : $signed(mul_p[35:16]);
                    r_state <= ST_DY1;
                end
                ST_DY1: begin
                    r_t     <= r_sin[19] ? -$signed(mul_p[35:16]) : $signed(mul_p[35:16]);
                    r_state <= ST_DY2;
                end
                ST_DY2: begin
                    r_dy    <= r_t[19] ? -$signed(mul_p[35:16]) : $signed(mul_p[35:16]);
                    r_state <= ST_WR;
                end
                ST_WR: r_state <= ST_OUT;
                ST_RD: r_state <= ST_LD;
                ST_LD: begin
                    r_x     <= rd_entry.x;
                    r_y     <= rd_entry.y;
                    r_dep   <= rd_entry.depth;
                    r_ph    <= rd_entry.phase;
                    r_dx    <= rd_entry.dx;
                    r_dy    <= rd_entry.dy;
                    r_state <= ST_MX;
                end
                ST_MX: begin
                    r_x     <= r_dx[19] ? r_x - mul_p[39:24] : r_x + mul_p[39:24];
                    r_state <= ST_MY;
                end
                ST_MY: begin
                    r_y     <= r_dy[19] ? r_y - mul_p[39:24] : r_y + mul_p[39:24];
                    r_state <= ST_PAR;
                end
                ST_PAR: begin
                    r_par   <= 11'((36'(mul_p[35:0]) + 36'd32768) >> 16);
                    r_state <= ST_PX;
                end
                ST_PX: begin
                    r_px    <= off_x[16] ? r_x - mul_p[31:16] : r_x + mul_p[31:16];
                    r_state <= ST_PY;
                end
                ST_PY: begin
                    r_py    <= off_y[16] ? r_y - mul_p[31:16] : r_y + mul_p[31:16];
                    r_state <= ST_TRN;
                end
                ST_TRN: begin
                    r_turn  <= mul_p[47:32] + r_ph;
                    r_ret   <= ST_TWK;
                    r_state <= ST_SIN0;
                end
                ST_TWK: begin
                    r_twk   <= r_sin[19] ? 17'd44237 - mul_p[32:16] : 17'd44237 + mul_p[32:16];
                    r_state <= ST_BR;
                end
                ST_BR: begin
                    r_br    <= mul_p[32:16];
                    r_state <= ST_SZ;
                end
                ST_SZ: begin
                    r_sz    <= 15'(36'd3277 + ((36'(mul_p[35:0]) + 36'd32768) >> 16));
                    r_state <= ST_WR;
                end
                ST_OUT: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_index  <= r_cmd.index;
            r_o_px     <= r_px;
            r_o_py     <= r_py;
            r_o_sz     <= r_sz;
            r_o_br     <= r_br;
            r_o_status <= r_cmd.status;
        end
    end

    assign ram_we         = (r_state == ST_WR);
    assign ram_addr       = AW'(r_cmd.index);
    assign wr_entry.x     = r_x;
    assign wr_entry.y     = r_y;
    assign wr_entry.depth = r_dep;
    assign wr_entry.phase = r_ph;
    assign wr_entry.dx    = r_dx;
    assign wr_entry.dy    = r_dy;
    assign rd_entry       = pfs_pkg::t_entry'(rd_data);

    pfs_ram #(
        .W     (pfs_pkg::ENTRY_W),
        .DEPTH (MAX_PARTICLES),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (wr_entry),
        .i_raddr (ram_addr),
        .o_rdata (rd_data)
    );

    assign o_out_valid      = r_ovalid;
    assign o_particle_index = r_o_index;
    assign o_pos_x          = r_o_px;
    assign o_pos_y          = r_o_py;
    assign o_size           = r_o_sz;
    assign o_brightness     = r_o_br;
    assign o_status         = r_o_status;

    a_write_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (!r_cmd.status &&
                    (r_cmd.func == pfs_pkg::FUNC_LAY || r_cmd.func == pfs_pkg::FUNC_STEP)))
        else $error("table written for a rejected or non-table command");

    a_reseed_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_cmd.func == pfs_pkg::FUNC_SEED) |=>
        (r_gen == (($past(i_seed) != '0) ? $past(i_seed) : pfs_pkg::DEFAULT_SEED)))
        else $error("reseed did not load the generator");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_o_status) |->
        (r_o_px == '0 && r_o_py == '0 && r_o_sz == '0 && r_o_br == '0))
        else $error("rejected result carries nonzero fields");

    a_gen_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_gen) |-> ($past(!i_rst_n) || $past(r_state) == ST_DRAW || $past(pop)))
        else $error("generator advanced outside a draw or reseed");

endmodule

// ===== rtl/particle_field_step_unit.sv =====
// Top level of the particle field step unit: front end, command queue, back end.
// Depends on pfs_pkg, pfs_front, pfs_queue and pfs_back.
//
// Usage. The input channel (i_in_valid / o_in_ready) carries one command per
// beat: func 0 reseeds the xorshift generator from the seed register, func 1
// lays out the particle at i_index from five generator draws, func 2 advances
// that particle by the clamped dt and reports its parallax-shifted position,
// size and twinkling brightness. Every accepted beat yields exactly one result
// beat on the output channel (o_out_valid / i_out_ready), in order. The
// configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes the
// particle count (index 0) or the seed (index 1); write it only while idle.
// A reseed, an unused func or a rejected index goes straight to the output; a
// step or a lay out runs through the back end sequencer, which handles one
// command at a time, runs most products through one shared multiplier and
// evaluates the sine series one product after another. A result also waits
// behind any earlier commands in the queue. The front end keeps accepting
// beats into a two-entry queue while the back end works or while the output
// register waits on a stalled receiver. Reset clears the queue, the
// configuration registers and the output valid, and loads the generator with
// its default seed; the particle table is not cleared and must be laid out
// before it is stepped.
module particle_field_step_unit #(
    parameter int MAX_PARTICLES = pfs_pkg::MAX_PARTICLES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_func,
    input  logic [10:0]        i_index,
    input  logic signed [23:0] i_step_seconds,
    input  logic [31:0]        i_clock_req,
    input  logic [15:0]        i_pointer_x,
    input  logic [15:0]        i_pointer_y,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [10:0]        o_particle_index,
    output logic [15:0]        o_pos_x,
    output logic [15:0]        o_pos_y,
    output logic [14:0]        o_size,
    output logic [16:0]        o_brightness,
    output logic               o_status,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    // Classified commands travel from front to back through the queue.
    pfs_pkg::t_cmd push_cmd;
    pfs_pkg::t_cmd pop_cmd;
    logic          push;
    logic          q_ready;
    logic          q_valid;
    logic          pop;
    logic [31:0]   seed;

    pfs_front #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_index        (i_index),
        .i_step_seconds (i_step_seconds),
        .i_clock_req    (i_clock_req),
        .i_pointer_x    (i_pointer_x),
        .i_pointer_y    (i_pointer_y),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_q_ready      (q_ready),
        .o_push         (push),
        .o_cmd          (push_cmd),
        .o_seed         (seed)
    );

    pfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (pop_cmd),
        .i_pop   (pop)
    );

    // The back end owns the table, the generator and the output register.
    pfs_back #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_cmd            (pop_cmd),
        .o_pop            (pop),
        .i_seed           (seed),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_particle_index (o_particle_index),
        .o_pos_x          (o_pos_x),
        .o_pos_y          (o_pos_y),
        .o_size           (o_size),
        .o_brightness     (o_brightness),
        .o_status         (o_status)
    );

endmodule

// ===== tb/particle_field_step_unit_test.sv =====
// Self-checking testbench for the particle field step unit: directed table, then random.
// Depends on pfs_pkg and particle_field_step_unit; results are checked by a built-in predictor.
`timescale 1ns / 1ps

module particle_field_step_unit_test;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 7;
    localparam int IDLE_LIMIT   = 3000;
    localparam int SETTLE       = 50;
    localparam int HOLD_CYCLES  = 300;

    typedef struct {
        logic [1:0]  func;
        logic [10:0] index;
        logic [23:0] dt;
        logic [31:0] clk_req;
        logic [15:0] ptr_x;
        logic [15:0] ptr_y;
    } t_tb_cmd;

    typedef struct {
        logic [10:0] index;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [14:0] size;
        logic [16:0] bright;
        logic        status;
    } t_result;

    // A row of the directed table is either a command beat or a register write.
    typedef enum logic { ROW_CMD, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [1:0]  code;      // func for a command, register index for a write
        logic [10:0] index;
        logic [31:0] data;      // dt for a command, write data for a register
        logic [31:0] clk_req;
        logic [15:0] ptr_x;
        logic [15:0] ptr_y;
        logic        typed;     // result written out by hand: all zero but index, status
        logic        typed_status;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_func = '0;
    logic [10:0] i_index = '0;
    logic signed [23:0] i_step_seconds = '0;
    logic [31:0] i_clock_req = '0;
    logic [15:0] i_pointer_x = '0;
    logic [15:0] i_pointer_y = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [10:0] o_particle_index;
    logic [15:0] o_pos_x;
    logic [15:0] o_pos_y;
    logic [14:0] o_size;
    logic [16:0] o_brightness;
    logic        o_status;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    particle_field_step_unit dut (.*);

    always #HALF_PERIOD i_clk = ~i_clk;

    // Predictor state: the particle table, the generator and both registers.
    pfs_pkg::t_entry particle_table [pfs_pkg::MAX_PARTICLES_DEF];
    bit          laid_out [pfs_pkg::MAX_PARTICLES_DEF];
    int          laid_out_list [$];
    logic [31:0] gen_state = pfs_pkg::DEFAULT_SEED;
    logic [11:0] count_reg = '0;
    logic [31:0] seed_reg = '0;

    t_result     pending_results [$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          hold_request = 1'b0;

    // Signed product shifted right, rounded toward zero.
    function automatic longint mul_shift(longint a, longint b, int sh);
        longint unsigned p;
        p = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) >> sh;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    // Seventh-order series for sin(2*pi*t), t a Q0.16 turn; result in Q.16.
    function automatic longint sine_of_turns(logic [15:0] t);
        longint unsigned mag, a, a2, a3, a5, a7, pos, negp;
        longint r;
        mag  = t[15] ? (64'h10000 - t) : t;
        a    = (mag * 64'd105414357) >> 16;
        a2   = (a * a) >> 24;
        a3   = (a2 * a) >> 24;
        a5   = (a3 * a2) >> 24;
        a7   = (a5 * a2) >> 24;
        pos  = a + a5 / 120;
        negp = a3 / 6 + a7 / 5040;
        r = (pos >= negp) ? longint'((pos - negp) >> 8) : -longint'((negp - pos) >> 8);
        return t[15] ? -r : r;
    endfunction

    function automatic logic [15:0] next_draw();
        logic [31:0] s;
        s = gen_state;
        s ^= s << 13;
        s ^= s >> 17;
        s ^= s << 5;
        gen_state = s;
        return s[23:8];
    endfunction

    // Applies one accepted command to the predictor and returns what the block must report.
    function automatic t_result predict_command(t_tb_cmd c);
        t_result     r;
        int          limit;
        logic [15:0] d, angle, turns;
        longint      speed, dt, par, twinkle, base;
        pfs_pkg::t_entry e;
        r = '{index: c.index, default: '0};
        limit = (count_reg > pfs_pkg::MAX_PARTICLES_DEF) ? pfs_pkg::MAX_PARTICLES_DEF
                                                         : count_reg;
        if (c.func == pfs_pkg::FUNC_SEED) begin
            gen_state = (seed_reg != 0) ? seed_reg : pfs_pkg::DEFAULT_SEED;
        end else if (c.func == pfs_pkg::FUNC_LAY || c.func == pfs_pkg::FUNC_STEP) begin
            if (c.index >= limit) begin
                r.status = 1'b1;
            end else if (c.func == pfs_pkg::FUNC_LAY) begin
                e.x = next_draw();
                e.y = next_draw();
                d = next_draw();
                e.depth = 16'((32'(d) * 32'(d)) >> 16);
                e.phase = next_draw();
                speed = 67109 + ((longint'(e.depth) * 335544 + 32768) >> 16);
                angle = next_draw();
                e.dx = 20'(mul_shift(sine_of_turns(angle + 16'h4000), speed, 16));
                e.dy = 20'(mul_shift(mul_shift(sine_of_turns(angle), speed, 16), 26214, 16));
                particle_table[c.index] = e;
                if (!laid_out[c.index]) begin
                    laid_out[c.index] = 1'b1;
                    laid_out_list.push_back(c.index);
                end
            end else begin
                e = particle_table[c.index];
                dt = longint'($signed(c.dt));
                if (dt < 0) dt = 0;
                if (dt > pfs_pkg::DT_MAX) dt = pfs_pkg::DT_MAX;
                e.x = 16'(longint'(e.x) + mul_shift(e.dx, dt, 24));
                e.y = 16'(longint'(e.y) + mul_shift(e.dy, dt, 24));
                particle_table[c.index] = e;
                par = (longint'(e.depth) * 1966 + 32768) >> 16;
                r.pos_x = 16'(longint'(e.x) + mul_shift(longint'(c.ptr_x) - 32768, par, 16));
                r.pos_y = 16'(longint'(e.y) + mul_shift(longint'(c.ptr_y) - 32768, par, 16));
                turns = 16'((64'(c.clk_req) * 64'd1162060974) >> 32);
                twinkle = 44237 + mul_shift(21299, sine_of_turns(turns + e.phase), 16);
                base = 16384 + ((3 * longint'(e.depth)) >> 2);
                r.bright = 17'((base * twinkle) >> 16);
                r.size = 15'(3277 + ((longint'(e.depth) * 18022 + 32768) >> 16));
            end
        end
        return r;
    endfunction

    // Sender: holds one command on the input channel until the block takes the beat.
    // Valid is left high afterwards; the caller decides whether a gap follows.
    task automatic send_command(t_tb_cmd c, bit typed, bit typed_status);
        t_result r;
        i_func         = c.func;
        i_index        = c.index;
        i_step_seconds = c.dt;
        i_clock_req    = c.clk_req;
        i_pointer_x    = c.ptr_x;
        i_pointer_y    = c.ptr_y;
        i_in_valid     = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        r = predict_command(c);
        if (typed) r = '{index: c.index, status: typed_status, default: '0};
        pending_results.push_back(r);
        @(negedge i_clk);
    endtask

    // Register writes wait for the block to drain, then for the longest command to finish.
    task automatic write_register(logic [1:0] idx, logic [31:0] value);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == pfs_pkg::CFG_PARTICLE_COUNT) count_reg = value[11:0];
        else if (idx == pfs_pkg::CFG_SEED) seed_reg = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Random command: mostly well-formed lay outs and steps of laid-out particles,
    // with reseeds and out-of-range indices mixed in.
    function automatic t_tb_cmd random_command();
        t_tb_cmd c;
        int      pick;
        c.clk_req = $urandom;
        c.ptr_x   = 16'($urandom);
        c.ptr_y   = 16'($urandom);
        pick = $urandom_range(99);
        case ($urandom_range(3))
            0: c.dt = 24'($urandom);
            1: c.dt = 24'(-$urandom_range(100));
            default: c.dt = 24'($urandom_range(6600));
        endcase
        if (pick < 8) c.func = pfs_pkg::FUNC_SEED;
        else if (pick < 40 || laid_out_list.size() == 0) c.func = pfs_pkg::FUNC_LAY;
        else c.func = pfs_pkg::FUNC_STEP;
        if (c.func == pfs_pkg::FUNC_STEP) begin
            c.index = 11'(laid_out_list[$urandom_range(laid_out_list.size() - 1)]);
        end else if (count_reg < pfs_pkg::MAX_PARTICLES_DEF && $urandom_range(9) == 0) begin
            c.index = 11'($urandom_range(pfs_pkg::MAX_PARTICLES_DEF - 1, count_reg));
        end else if (count_reg == 0) begin
            c.index = 11'($urandom);
        end else begin
            c.index = 11'($urandom_range(count_reg - 1));
        end
        return c;
    endfunction

    t_row directed_rows [$] = '{
        // After reset the count is zero, so lay out and step are both rejected.
        '{ROW_CMD, pfs_pkg::FUNC_LAY,  11'd0,    32'd0, 32'd0, 16'd0, 16'd0, 1'b1, 1'b1},
        '{ROW_CMD, pfs_pkg::FUNC_STEP, 11'd2047, 32'd0, 32'd0, 16'd0, 16'd0, 1'b1, 1'b1},
        '{ROW_CMD, pfs_pkg::FUNC_SEED, 11'd5,    32'd0, 32'd0, 16'd0, 16'd0, 1'b1, 1'b0},
        '{ROW_CFG, pfs_pkg::CFG_PARTICLE_COUNT, 11'd0, 32'd2048, 32'd0, 16'd0, 16'd0,
          1'b0, 1'b0},
        '{ROW_CFG, pfs_pkg::CFG_SEED, 11'd0, 32'hFFFF_FFFF, 32'd0, 16'd0, 16'd0, 1'b0, 1'b0},
        '{ROW_CMD, pfs_pkg::FUNC_SEED, 11'd0,    32'd0, 32'd0, 16'd0, 16'd0, 1'b1, 1'b0},
        '{ROW_CMD, pfs_pkg::FUNC_LAY,  11'd0,    32'd0, 32'd0, 16'd0, 16'd0, 1'b0, 1'b0},
        '{ROW_CMD, pfs_pkg::FUNC_LAY,  11'd2047, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0, 1'b0},
        // Most negative dt clamps to zero; most positive clamps to the ceiling.
        '{ROW_CMD, pfs_pkg::FUNC_STEP, 11'd0, 32'h80_0000, 32'd0, 16'd0, 16'd0, 1'b0, 1'b0},
        '{ROW_CMD, pfs_pkg::FUNC_STEP, 11'd0, 32'h7F_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
          1'b0, 1'b0},
        '{ROW_CMD, pfs_pkg::FUNC_STEP, 11'd2047, 32'd6554, 32'h8000_0000, 16'h8000, 16'h8000,
          1'b0, 1'b0},
        '{ROW_CMD, pfs_pkg::FUNC_STEP, 11'd2047, 32'd6555, 32'h0001_0000, 16'h7FFF, 16'h0001,
          1'b0, 1'b0},
        '{ROW_CMD, pfs_pkg::FUNC_STEP, 11'd0, 32'd1, 32'h1234_5678, 16'h4000, 16'hC000,
          1'b0, 1'b0},
        // With a count of one, everything past entry zero is rejected.
        '{ROW_CFG, pfs_pkg::CFG_PARTICLE_COUNT, 11'd0, 32'd1, 32'd0, 16'd0, 16'd0, 1'b0, 1'b0},
        '{ROW_CMD, pfs_pkg::FUNC_LAY,  11'd1,    32'd0, 32'd0, 16'd0, 16'd0, 1'b1, 1'b1},
        '{ROW_CMD, pfs_pkg::FUNC_STEP, 11'd2047, 32'd0, 32'd0, 16'd0, 16'd0, 1'b1, 1'b1},
        '{ROW_CMD, pfs_pkg::FUNC_STEP, 11'd0, 32'd3000, 32'd77, 16'd9, 16'd65000, 1'b0, 1'b0},
        // A zero seed falls back to the default constant.
        '{ROW_CFG, pfs_pkg::CFG_SEED, 11'd0, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0, 1'b0},
        '{ROW_CMD, pfs_pkg::FUNC_SEED, 11'd0,    32'd0, 32'd0, 16'd0, 16'd0, 1'b1, 1'b0},
        '{ROW_CMD, pfs_pkg::FUNC_LAY,  11'd0,    32'd0, 32'd0, 16'd0, 16'd0, 1'b0, 1'b0},
        '{ROW_CMD, pfs_pkg::FUNC_STEP, 11'd0, 32'd6554, 32'hDEAD_BEEF, 16'd100, 16'd200,
          1'b0, 1'b0}
    };

    // Receiver: ready follows a random pattern, renewed after a random run, and
    // once on request it holds off for a long stretch so the queue backs up.
    initial begin : receiver
        int mode;
        int left;
        mode = 0;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_request = 1'b0;
            end
            if (left == 0) begin
                mode = $urandom_range(2);
                left = $urandom_range(20, 100);
            end
            left--;
            case (mode)
                0: i_out_ready = 1'b1;
                1: i_out_ready = 1'($urandom_range(1));
                default: i_out_ready = ($urandom_range(3) == 0);
            endcase
        end
    end

    // Result check: every beat taken from the output is matched with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: index %0d", o_particle_index);
            end else begin
                want = pending_results.pop_front();
                if (o_particle_index !== want.index || o_pos_x !== want.pos_x ||
                    o_pos_y !== want.pos_y || o_size !== want.size ||
                    o_brightness !== want.bright || o_status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected idx %0d x %0d y %0d size %0d br %0d ",
                                  "st %0d, got idx %0d x %0d y %0d size %0d br %0d st %0d"},
                                 want.index, want.pos_x, want.pos_y, want.size,
                                 want.bright, want.status, o_particle_index, o_pos_x,
                                 o_pos_y, o_size, o_brightness, o_status);
                end
            end
        end
    end

    // Watchdog: any beat on any channel restarts the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("particle_field_step_unit verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [31:0] phase_count [5];
        logic [31:0] phase_seed [5];
        int          phase_items [5];
        int          burst;
        t_tb_cmd     c;
        phase_count = '{32'd2048, 32'd1, 32'($urandom_range(2048, 2)), 32'd0, 32'd2048};
        phase_seed  = '{$urandom, 32'd0, 32'hFFFF_FFFF, $urandom, 32'd0};
        phase_items = '{290, 250, 290, 100, 290};

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                write_register(directed_rows[i].code, directed_rows[i].data);
            end else begin
                c = '{directed_rows[i].code, directed_rows[i].index,
                      directed_rows[i].data[23:0], directed_rows[i].clk_req,
                      directed_rows[i].ptr_x, directed_rows[i].ptr_y};
                send_command(c, directed_rows[i].typed, directed_rows[i].typed_status);
            end
        end

        // Random phases, each under its own register setting. The sender runs in
        // bursts; between bursts valid drops for a random gap before the next beat.
        for (int p = 0; p < 5; p++) begin
            write_register(pfs_pkg::CFG_PARTICLE_COUNT, phase_count[p]);
            write_register(pfs_pkg::CFG_SEED, phase_seed[p]);
            burst = 0;
            for (int n = 0; n < phase_items[p]; n++) begin
                if (p == 0 && n == 40) hold_request = 1'b1;
                if (burst == 0) begin
                    i_in_valid = 1'b0;
                    repeat ($urandom_range(1, 12)) @(negedge i_clk);
                    burst = ($urandom_range(4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 15);
                end
                burst--;
                send_command(random_command(), 1'b0, 1'b0);
            end
        end
        i_in_valid = 1'b0;

        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("particle_field_step_unit verification clean");
        end else begin
            $display("particle_field_step_unit verification failed");
        end
        $finish;
    end

endmodule
